@@ hw/rtl/rms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg - shared types and constants of the robot mode supervisor
// Mode codes, register indexes, field widths and the result bundle handed
// from the mode controller to the top level.
// ----------------------------------------------------------------------------
package rms_pkg;

  // Field widths fixed by the interface
  localparam int MODE_W    = 3;
  localparam int LEG_W     = 48;
  localparam int MAX_LEGS  = 4;
  localparam int THR_W     = 16;
  localparam int LIMIT_W   = 5;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Defaults for the top-level parameters
  localparam int NUM_LEGS_DEF   = 4;
  localparam int JOINTS_DEF     = 3;
  localparam int SPEED_BITS_DEF = 16;

  // Overspeed counter saturation point
  localparam int             COUNT_MAX_INT = 31;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 5'd31;

  // Register reset values
  localparam logic signed [THR_W-1:0] THR_RESET   = 16'sd2560;
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 5'd10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 1'b1;

  // Write-back value when no rewrite is requested
  localparam logic [MODE_W-1:0] OVR_NONE = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASSIVE = 3'd0,
    MODE_STAND   = 3'd1,
    MODE_SIT     = 3'd2,
    MODE_DAMPING = 3'd3,
    MODE_WALK    = 3'd4,
    MODE_WALK2   = 3'd5,
    MODE_USER    = 3'd6
  } mode_t;

  // Per-tick outcome of the mode controller
  typedef struct packed {
    logic [MODE_W-1:0] active;
    logic [MODE_W-1:0] pending;
    logic              ovr_valid;
    logic [MODE_W-1:0] ovr_mode;
    logic              fold;
    logic              exited;
  } mode_res_t;

endpackage

@@ hw/rtl/rms_leg_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_leg_lane - overspeed detector for one leg
// Compares every joint speed of the leg against the danger threshold and
// counts the joints that run strictly above it.
// ----------------------------------------------------------------------------
module rms_leg_lane #(
  parameter int JOINTS     = rms_pkg::JOINTS_DEF,
  parameter int SPEED_BITS = rms_pkg::SPEED_BITS_DEF,
  localparam int HIT_W     = $clog2(JOINTS + 1)
) (
  input  logic [rms_pkg::LEG_W-1:0]        speeds,
  input  logic signed [rms_pkg::THR_W-1:0] threshold,
  output logic [HIT_W-1:0]                 hits
);

  logic signed [SPEED_BITS-1:0]     joint_raw [JOINTS];
  logic signed [rms_pkg::THR_W-1:0] joint_ext [JOINTS];

  // Slice and sign-extend each joint speed
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      joint_raw[j] = $signed(speeds[j*SPEED_BITS +: SPEED_BITS]);
      joint_ext[j] = rms_pkg::THR_W'(joint_raw[j]);
    end
  end

  // Count joints above the threshold
  always_comb begin
    hits = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (joint_ext[j] > threshold) begin
        hits = hits + HIT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rms_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_merge - overspeed counter
// Sums the hit counts of all leg lanes into the saturating overspeed counter
// and raises the trip when the count exceeds the limit; a trip clears it.
// ----------------------------------------------------------------------------
module rms_merge #(
  parameter int NUM_LEGS = rms_pkg::NUM_LEGS_DEF,
  parameter int JOINTS   = rms_pkg::JOINTS_DEF,
  localparam int HIT_W   = $clog2(JOINTS + 1),
  localparam int TOT_W   = $clog2(NUM_LEGS * JOINTS + 1),
  localparam int SUM_W   = $clog2(rms_pkg::COUNT_MAX_INT + NUM_LEGS * JOINTS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic [rms_pkg::LIMIT_W-1:0]      limit,
  input  logic [NUM_LEGS-1:0][HIT_W-1:0]   hits,
  output logic                             trip
);

  logic [rms_pkg::CNT_W-1:0] count;
  logic [rms_pkg::CNT_W-1:0] count_next;
  logic [rms_pkg::CNT_W-1:0] count_sat;
  logic [TOT_W-1:0]          total;
  logic [SUM_W-1:0]          sum;

  // Combine the lane results
  always_comb begin
    total = '0;
    for (int l = 0; l < NUM_LEGS; l++) begin
      total = total + TOT_W'(hits[l]);
    end
  end

  // Saturate, compare against the limit, clear on trip
  always_comb begin
    sum        = SUM_W'(count) + SUM_W'(total);
    count_sat  = (sum > SUM_W'(rms_pkg::COUNT_MAX)) ? rms_pkg::COUNT_MAX
                                                    : sum[rms_pkg::CNT_W-1:0];
    trip       = (count_sat > limit);
    count_next = trip ? '0 : count_sat;
  end

  // Advance the counter once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (adv) begin
      count <= count_next;
    end
  end

endmodule

@@ hw/rtl/rms_mode_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_mode_ctrl - mode transition controller
// Holds the active and pending modes and the stand fold flag, checks the
// command against the allowed transitions, applies a forced damping request
// and performs the switch once the active mode is not busy and entry is allowed.
// ----------------------------------------------------------------------------
module rms_mode_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [rms_pkg::MODE_W-1:0]        cmd,
  input  logic                              busy,
  input  logic                              entry_ok,
  input  logic                              trip,
  output rms_pkg::mode_res_t                res
);

  rms_pkg::mode_t active;
  rms_pkg::mode_t active_next;
  rms_pkg::mode_t pending;
  rms_pkg::mode_t pending_next;
  logic           fold;
  logic           fold_next;

  rms_pkg::mode_t target;
  rms_pkg::mode_t pend_req;
  rms_pkg::mode_t pend_trip;
  logic           take;
  logic           rewrite;
  logic           exited;

  // Hold the mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= rms_pkg::MODE_PASSIVE;
      pending <= rms_pkg::MODE_PASSIVE;
      fold    <= 1'b0;
    end else if (adv) begin
      active  <= active_next;
      pending <= pending_next;
      fold    <= fold_next;
    end
  end

  // Decide on the command, then apply trip and switch
  always_comb begin
    target    = rms_pkg::MODE_PASSIVE;
    take      = 1'b0;
    rewrite   = 1'b0;
    fold_next = fold;

    if (pending == active) begin
      unique case (active)
        rms_pkg::MODE_PASSIVE: begin
          if (cmd == rms_pkg::MODE_STAND) begin
            fold_next = 1'b1;
            target    = rms_pkg::MODE_STAND;
            take      = 1'b1;
          end else if (cmd == rms_pkg::MODE_USER) begin
            target = rms_pkg::MODE_USER;
            take   = 1'b1;
          end else begin
            rewrite = 1'b1;
          end
        end
        rms_pkg::MODE_STAND: begin
          if (!busy) begin
            if (cmd == rms_pkg::MODE_SIT || cmd == rms_pkg::MODE_DAMPING ||
                cmd == rms_pkg::MODE_WALK || cmd == rms_pkg::MODE_WALK2) begin
              target = rms_pkg::mode_t'(cmd);
              take   = 1'b1;
            end else begin
              rewrite = 1'b1;
            end
          end
        end
        rms_pkg::MODE_SIT, rms_pkg::MODE_DAMPING: begin
          if (!busy) begin
            if (cmd == rms_pkg::MODE_STAND) begin
              fold_next = 1'b1;
              target    = rms_pkg::MODE_STAND;
              take      = 1'b1;
            end else if (cmd == rms_pkg::MODE_PASSIVE) begin
              target = rms_pkg::MODE_PASSIVE;
              take   = 1'b1;
            end else begin
              rewrite = 1'b1;
            end
          end
        end
        rms_pkg::MODE_WALK, rms_pkg::MODE_WALK2: begin
          if (!busy) begin
            if (cmd == rms_pkg::MODE_STAND) begin
              fold_next = 1'b0;
              target    = rms_pkg::MODE_STAND;
              take      = 1'b1;
            end else if (cmd == rms_pkg::MODE_DAMPING) begin
              target = rms_pkg::MODE_DAMPING;
              take   = 1'b1;
            end else begin
              rewrite = 1'b1;
            end
          end
        end
        rms_pkg::MODE_USER: begin
          // User interface mode ignores anything but damping, no rewrite
          if (!busy && cmd == rms_pkg::MODE_DAMPING) begin
            target = rms_pkg::MODE_DAMPING;
            take   = 1'b1;
          end
        end
        default: begin
          take    = 1'b0;
          rewrite = 1'b0;
        end
      endcase
    end

    pend_req  = take ? target : pending;
    pend_trip = trip ? rms_pkg::MODE_DAMPING : pend_req;

    // Switch when a change is pending, the active mode is free and entry is allowed
    exited       = (pend_trip != active) && !busy;
    active_next  = (exited && entry_ok) ? pend_trip : active;
    pending_next = (exited && !entry_ok) ? active : pend_trip;

    res.active    = active_next;
    res.pending   = pending_next;
    res.ovr_valid = rewrite;
    res.ovr_mode  = rewrite ? active : rms_pkg::OVR_NONE;
    res.fold      = fold_next;
    res.exited    = exited;
  end

endmodule

@@ hw/rtl/robot_mode_supervisor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_mode_supervisor - per-tick mode supervisor for a legged robot
// The result of a tick is registered at the edge that accepts it and shown on
// the output from the next cycle. One tick is accepted per cycle while the
// output register is free or being drained; the leg lanes, counter merge and
// mode table are combinational and the output register decouples the two
// sides. Reset puts the robot in passive mode, clears the overspeed counter
// and fold flag, and loads the default threshold and limit.
// ----------------------------------------------------------------------------
module robot_mode_supervisor #(
  parameter int NUM_LEGS       = rms_pkg::NUM_LEGS_DEF,
  parameter int JOINTS_PER_LEG = rms_pkg::JOINTS_DEF,
  parameter int SPEED_BITS     = rms_pkg::SPEED_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_we,
  input  logic [rms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rms_pkg::CFG_W-1:0]         cfg_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rms_pkg::MODE_W-1:0]        commanded_mode,
  input  logic                              current_busy,
  input  logic                              entry_ok,
  input  logic [rms_pkg::LEG_W-1:0]         leg0_speeds,
  input  logic [rms_pkg::LEG_W-1:0]         leg1_speeds,
  input  logic [rms_pkg::LEG_W-1:0]         leg2_speeds,
  input  logic [rms_pkg::LEG_W-1:0]         leg3_speeds,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rms_pkg::MODE_W-1:0]        active_mode,
  output logic [rms_pkg::MODE_W-1:0]        pending_mode,
  output logic                              override_valid,
  output logic [rms_pkg::MODE_W-1:0]        override_mode,
  output logic                              stand_fold,
  output logic                              danger_trip,
  output logic                              mode_exited
);

  localparam int HIT_W = $clog2(JOINTS_PER_LEG + 1);

  logic signed [rms_pkg::THR_W-1:0]       threshold;
  logic [rms_pkg::LIMIT_W-1:0]            limit;
  logic                                   adv;
  logic [rms_pkg::MAX_LEGS-1:0][rms_pkg::LEG_W-1:0] leg_words;
  logic [NUM_LEGS-1:0][HIT_W-1:0]         hits;
  logic                                   trip;
  rms_pkg::mode_res_t                     res;

  // Accept a beat whenever the output register is free or being drained
  assign in_stall = out_valid && out_stall;
  assign adv      = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rms_pkg::THR_RESET;
      limit     <= rms_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rms_pkg::CFG_THRESHOLD: threshold <= $signed(cfg_data[rms_pkg::THR_W-1:0]);
        rms_pkg::CFG_LIMIT:     limit     <= cfg_data[rms_pkg::LIMIT_W-1:0];
        default: begin
          threshold <= threshold;
        end
      endcase
    end
  end

  // Leg lanes, one per leg
  assign leg_words = {leg3_speeds, leg2_speeds, leg1_speeds, leg0_speeds};

  for (genvar l = 0; l < NUM_LEGS; l++) begin : g_lane
    rms_leg_lane #(
      .JOINTS     (JOINTS_PER_LEG),
      .SPEED_BITS (SPEED_BITS)
    ) u_lane (
      .speeds    (leg_words[l]),
      .threshold (threshold),
      .hits      (hits[l])
    );
  end

  // Merge lane hits into the overspeed counter
  rms_merge #(
    .NUM_LEGS (NUM_LEGS),
    .JOINTS   (JOINTS_PER_LEG)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .limit (limit),
    .hits  (hits),
    .trip  (trip)
  );

  // Mode transitions
  rms_mode_ctrl u_mode (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cmd      (commanded_mode),
    .busy     (current_busy),
    .entry_ok (entry_ok),
    .trip     (trip),
    .res      (res)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      active_mode    <= res.active;
      pending_mode   <= res.pending;
      override_valid <= res.ovr_valid;
      override_mode  <= res.ovr_mode;
      stand_fold     <= res.fold;
      danger_trip    <= trip;
      mode_exited    <= res.exited;
    end
  end

`ifndef SYNTH
  // A completed switch attempt leaves nothing pending
  a_exit_settles: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_exited |-> pending_mode == active_mode)
    else $error("pending mode left open after a switch attempt");

  // A rewritten command never comes with a switch unless damping was forced
  a_rewrite_no_exit: assert property (@(posedge clk) disable iff (rst)
    out_valid && override_valid && !danger_trip |-> !mode_exited)
    else $error("switch reported together with a rejected command");

  // Write-back value is zero when no rewrite is asked
  a_ovr_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !override_valid |-> override_mode == rms_pkg::OVR_NONE)
    else $error("override mode set without override valid");

  // An empty output register never holds off the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");
`endif

endmodule
